FILE: design/stpg_pkg.sv
// Shared types, codes and the color function of the spiral test pattern generator.
// No dependencies; the top level refers to this package by scoped names.
package stpg_pkg;

	// Fixed field widths of the stream beats
	localparam int COORD_W = 10;
	localparam int COLOR_W = 8;
	localparam int FRAME_W = 8;

	// Request kind carried in tuser
	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	// Walk headings, clockwise
	localparam logic [1:0] DIR_EAST  = 2'd0;  // col+1
	localparam logic [1:0] DIR_SOUTH = 2'd1;  // row+1
	localparam logic [1:0] DIR_WEST  = 2'd2;  // col-1
	localparam logic [1:0] DIR_NORTH = 2'd3;  // row-1

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CLEAR = 9'b000000010,
		ST_SEED  = 9'b000000100,
		ST_PROBE = 9'b000001000,
		ST_CHECK = 9'b000010000,
		ST_RDIV  = 9'b000100000,
		ST_RMEM  = 9'b001000000,
		ST_RDATA = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	// RGB332 byte of shade b: red = 6b, green = 7b, blue = b (all mod 256)
	function automatic logic [COLOR_W-1:0] shade(input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] g;
		r = 8'(b * 8'd6);
		g = 8'(b * 8'd7);
		shade = {r[7:5], g[7:5], b[7:6]};
	endfunction

endpackage

FILE: design/spiral_test_pattern_generator_unit.sv
// Spiral test pattern generator: sequencer, visited map, canvas memory and pixel lookup.
// Depends on stpg_pkg (types, codes, shade function).
//
// Usage:
//   Input stream (s_*): one beat per request. tuser = req_type (0 frame tick,
//   1 pixel read); tdata carries pix_x and pix_y of a pixel read.
//   Output stream (m_*): one beat per request with the pixel color (0 for a
//   frame tick) and the low byte of the frame counter after the request.
//   Pixel read: the screen coordinate is mapped to a canvas cell by a
//   reciprocal multiply, then the canvas memory is read. The cell index,
//   the canvas read and the result are registered in turn (ST_RDIV, ST_RMEM,
//   ST_RDATA) before the result is loaded into the output register.
//   Frame tick: the visited map is cleared, one entry per cycle, then the
//   seed cell is painted and the walk paints each further cell after a probe
//   state and a check state; a wall turns the heading in the probe state, a
//   painted cell in the check state.
//   The block takes no input beat while a request is in work.
//   Reset: frame counter 0, canvas reads black until the first frame tick;
//   no clearing pass runs after reset.
//   Receiver stall: the result waits in the output register; the block still
//   takes and works the next request and holds its result until the register
//   frees up.
module spiral_test_pattern_generator_unit #(
	parameter int GRID     = 32,
	parameter int SCREEN_W = 800,
	parameter int SCREEN_H = 600
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] pix_x, [19:10] pix_y, [23:20] zero
	input  logic        s_tuser,   // [0] req_type
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] color, [15:8] frame_low
);

	localparam int CELLS = GRID * GRID;
	localparam int RW    = $clog2(GRID);
	localparam int AW    = $clog2(CELLS);
	localparam int KW    = $clog2(CELLS + 1);
	localparam int CW    = stpg_pkg::COORD_W;

	// Exact division of a CW-bit coordinate by a constant: q = (n * M) >> S
	localparam int DIV_X = SCREEN_W / GRID;
	localparam int DIV_Y = SCREEN_H / GRID;
	localparam int SH_X  = CW + $clog2(DIV_X);
	localparam int SH_Y  = CW + $clog2(DIV_Y);
	localparam int MUL_X = ((1 << SH_X) + DIV_X - 1) / DIV_X;
	localparam int MUL_Y = ((1 << SH_Y) + DIV_Y - 1) / DIV_Y;
	localparam int MXW   = $clog2(MUL_X + 1);
	localparam int MYW   = $clog2(MUL_Y + 1);

	stpg_pkg::state_t state_q;

	logic [stpg_pkg::FRAME_W-1:0] frame_q;
	logic                         painted_q;
	logic [KW-1:0]                k_q;
	logic [1:0]                   t_q;
	logic [1:0]                   dir_q;
	logic [RW-1:0]                row_q;
	logic [RW-1:0]                col_q;
	logic [AW-1:0]                clr_q;
	logic                         out_valid_q;

	logic [RW-1:0]                cand_row_q;
	logic [RW-1:0]                cand_col_q;
	logic [AW-1:0]                cand_addr_q;
	logic [CW-1:0]                x_q;
	logic [CW-1:0]                y_q;
	logic [RW-1:0]                cr_q;
	logic [RW-1:0]                cc_q;
	logic                         inrange_q;
	logic [stpg_pkg::COLOR_W-1:0] res_color_q;
	logic [stpg_pkg::COLOR_W-1:0] m_color_q;
	logic [stpg_pkg::FRAME_W-1:0] m_frame_q;

	// Memories
	logic                         vis_mem [CELLS];
	logic [stpg_pkg::COLOR_W-1:0] can_mem [CELLS];
	logic                         vis_rd_q;
	logic [stpg_pkg::COLOR_W-1:0] can_rd_q;

	logic                         vis_we, vis_wdata, vis_re;
	logic [AW-1:0]                vis_waddr, vis_raddr;
	logic                         can_we, can_re;
	logic [AW-1:0]                can_waddr, can_raddr;
	logic [stpg_pkg::COLOR_W-1:0] can_wdata;

	logic [RW-1:0] nr, nc;
	logic          inb;
	logic [AW-1:0] nb_addr;
	logic [KW-1:0] k_next;
	logic          k_last;
	logic          step_fail, step_move;
	logic          in_beat, out_load;
	logic [7:0]    walk_shade;

	logic [CW+MXW-1:0] prod_x;
	logic [CW+MYW-1:0] prod_y;
	logic [CW-1:0]     qx, qy;

	// Handshake
	assign s_tready = (state_q == stpg_pkg::ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_load = (state_q == stpg_pkg::ST_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {m_frame_q, m_color_q};

	// Neighbor cell in the current heading, with bounds check
	always_comb begin
		nr  = row_q;
		nc  = col_q;
		inb = 1'b0;
		case (dir_q)
			stpg_pkg::DIR_EAST: begin
				nc  = col_q + RW'(1);
				inb = (col_q != RW'(GRID - 1));
			end
			stpg_pkg::DIR_SOUTH: begin
				nr  = row_q + RW'(1);
				inb = (row_q != RW'(GRID - 1));
			end
			stpg_pkg::DIR_WEST: begin
				nc  = col_q - RW'(1);
				inb = (col_q != '0);
			end
			stpg_pkg::DIR_NORTH: begin
				nr  = row_q - RW'(1);
				inb = (row_q != '0);
			end
			default: begin
				inb = 1'b0;
			end
		endcase
	end

	assign nb_addr    = AW'(AW'(nr) * AW'(GRID)) + AW'(nc);
	assign k_next     = k_q + KW'(1);
	assign k_last     = (k_next == KW'(CELLS));
	assign step_fail  = ((state_q == stpg_pkg::ST_PROBE) && !inb) ||
	                    ((state_q == stpg_pkg::ST_CHECK) && vis_rd_q);
	assign step_move  = (state_q == stpg_pkg::ST_CHECK) && !vis_rd_q;
	assign walk_shade = frame_q + 8'(k_q >> 1);

	// Coordinate to cell by reciprocal multiply
	assign prod_x = (CW+MXW)'(x_q) * (CW+MXW)'(MUL_X);
	assign prod_y = (CW+MYW)'(y_q) * (CW+MYW)'(MUL_Y);
	assign qx     = CW'(prod_x >> SH_X);
	assign qy     = CW'(prod_y >> SH_Y);

	// Visited map port control
	always_comb begin
		vis_we    = 1'b0;
		vis_wdata = 1'b0;
		vis_waddr = clr_q;
		vis_re    = 1'b0;
		vis_raddr = nb_addr;
		case (state_q)
			stpg_pkg::ST_CLEAR: begin
				vis_we = 1'b1;
			end
			stpg_pkg::ST_SEED: begin
				vis_we    = 1'b1;
				vis_wdata = 1'b1;
				vis_waddr = '0;
			end
			stpg_pkg::ST_PROBE: begin
				vis_re = inb;
			end
			stpg_pkg::ST_CHECK: begin
				vis_we    = !vis_rd_q;
				vis_wdata = 1'b1;
				vis_waddr = cand_addr_q;
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	// Canvas port control
	always_comb begin
		can_we    = 1'b0;
		can_waddr = cand_addr_q;
		can_wdata = stpg_pkg::shade(walk_shade);
		can_re    = (state_q == stpg_pkg::ST_RMEM);
		can_raddr = AW'(AW'(cr_q) * AW'(GRID)) + AW'(cc_q);
		if (state_q == stpg_pkg::ST_SEED) begin
			can_we    = 1'b1;
			can_waddr = '0;
			can_wdata = stpg_pkg::shade(frame_q);
		end else if (step_move) begin
			can_we = 1'b1;
		end
	end

	// Visited map memory
	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		if (vis_re) begin
			vis_rd_q <= vis_mem[vis_raddr];
		end
	end

	// Canvas memory
	always_ff @(posedge clk) begin
		if (can_we) begin
			can_mem[can_waddr] <= can_wdata;
		end
		if (can_re) begin
			can_rd_q <= can_mem[can_raddr];
		end
	end

	// Sequencer and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stpg_pkg::ST_IDLE;
			frame_q     <= '0;
			painted_q   <= 1'b0;
			k_q         <= '0;
			t_q         <= '0;
			dir_q       <= stpg_pkg::DIR_EAST;
			row_q       <= '0;
			col_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				stpg_pkg::ST_IDLE: begin
					if (in_beat) begin
						if (s_tuser == stpg_pkg::REQ_PIXEL) begin
							state_q <= stpg_pkg::ST_RDIV;
						end else begin
							frame_q <= frame_q + 8'd1;
							clr_q   <= '0;
							state_q <= stpg_pkg::ST_CLEAR;
						end
					end
				end
				stpg_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= stpg_pkg::ST_SEED;
					end
				end
				stpg_pkg::ST_SEED: begin
					painted_q <= 1'b1;
					row_q     <= '0;
					col_q     <= '0;
					dir_q     <= stpg_pkg::DIR_EAST;
					t_q       <= '0;
					k_q       <= KW'(1);
					state_q   <= stpg_pkg::ST_PROBE;
				end
				stpg_pkg::ST_PROBE, stpg_pkg::ST_CHECK: begin
					if (step_move) begin
						row_q   <= cand_row_q;
						col_q   <= cand_col_q;
						t_q     <= '0;
						k_q     <= k_next;
						state_q <= k_last ? stpg_pkg::ST_DONE : stpg_pkg::ST_PROBE;
					end else if (step_fail) begin
						// turn clockwise; four turns in a row give up this step
						dir_q <= dir_q + 2'd1;
						if (t_q == 2'd3) begin
							t_q     <= '0;
							k_q     <= k_next;
							state_q <= k_last ? stpg_pkg::ST_DONE : stpg_pkg::ST_PROBE;
						end else begin
							t_q     <= t_q + 2'd1;
							state_q <= stpg_pkg::ST_PROBE;
						end
					end else begin
						state_q <= stpg_pkg::ST_CHECK;
					end
				end
				stpg_pkg::ST_RDIV: begin
					state_q <= stpg_pkg::ST_RMEM;
				end
				stpg_pkg::ST_RMEM: begin
					state_q <= stpg_pkg::ST_RDATA;
				end
				stpg_pkg::ST_RDATA: begin
					state_q <= stpg_pkg::ST_DONE;
				end
				stpg_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= stpg_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= stpg_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q         <= s_tdata[CW-1:0];
			y_q         <= s_tdata[2*CW-1:CW];
			res_color_q <= '0;
		end
		if ((state_q == stpg_pkg::ST_PROBE) && inb) begin
			cand_row_q  <= nr;
			cand_col_q  <= nc;
			cand_addr_q <= nb_addr;
		end
		if (state_q == stpg_pkg::ST_RDIV) begin
			cr_q      <= qy[RW-1:0];
			cc_q      <= qx[RW-1:0];
			inrange_q <= ({1'b0, qy} < (CW+1)'(GRID)) && ({1'b0, qx} < (CW+1)'(GRID));
		end
		if (state_q == stpg_pkg::ST_RDATA) begin
			res_color_q <= (painted_q && inrange_q) ? can_rd_q : '0;
		end
		if (out_load) begin
			m_color_q <= res_color_q;
			m_frame_q <= frame_q;
		end
	end

	// Checks
	a_tick_advances_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (s_tuser == stpg_pkg::REQ_FRAME)) |=> (frame_q == $past(frame_q) + 8'd1))
		else $error("frame counter did not advance on frame tick");

	a_read_keeps_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (s_tuser == stpg_pkg::REQ_PIXEL)) |=> $stable(frame_q))
		else $error("frame counter changed on pixel read");

	a_walk_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == stpg_pkg::ST_PROBE) || (state_q == stpg_pkg::ST_CHECK)) |->
		((k_q != '0) && (k_q < KW'(CELLS))))
		else $error("walk step index out of range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == stpg_pkg::ST_DONE) && out_valid_q && !m_tready) |=>
		((state_q == stpg_pkg::ST_DONE) && out_valid_q))
		else $error("result overwrote a stalled output beat");

endmodule

FILE: dv/tb_spiral_test_pattern_generator_unit.sv
`timescale 1ns / 100ps
// Testbench for the spiral test pattern generator: frame ticks and pixel reads
// with random stalls on both streams, checked against an in-bench spiral model.
// Depends on stpg_pkg and spiral_test_pattern_generator_unit.
module tb_spiral_test_pattern_generator_unit;

	localparam int GRID      = 32;
	localparam int SCREEN_W  = 800;
	localparam int SCREEN_H  = 600;
	localparam int CELLS     = GRID * GRID;
	localparam int CELL_W    = SCREEN_W / GRID;
	localparam int CELL_H    = SCREEN_H / GRID;
	localparam int HANG_LIMIT = 20000;  // quiet-cycle limit, longer than a frame tick takes
	localparam int SETTLE     = 12;
	localparam int MAX_PRINTS = 100;

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] frame_low;
	} pixel_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [9:0] pix_x, [19:10] pix_y, [23:20] zero
	logic        s_tuser = 1'b0; // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] color, [15:8] frame_low

	// Model state
	logic [7:0]  frame_model;
	logic [7:0]  canvas_model [CELLS];
	bit          walked [CELLS];
	pixel_beat_t owed_beats [$];
	int          err_count;
	bit          idling_on;

	spiral_test_pattern_generator_unit #(
		.GRID     (GRID),
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// RGB332 byte: red = 6b, green = 7b, blue = b, each mod 256, top bits kept
	function automatic logic [7:0] rgb332(input logic [7:0] b);
		int unsigned red;
		int unsigned green;
		red   = (b * 6) & 8'hFF;
		green = (b * 7) & 8'hFF;
		return 8'((red & 8'hE0) | ((green & 8'hE0) >> 3) | ((b & 8'hC0) >> 6));
	endfunction

	// Repaint the canvas along the clockwise spiral for the current frame
	task automatic repaint_canvas();
		int row;
		int col;
		int nr;
		int nc;
		logic [1:0] hd;
		for (int i = 0; i < CELLS; i++)
			walked[i] = 1'b0;
		row = 0;
		col = 0;
		hd  = stpg_pkg::DIR_EAST;
		canvas_model[0] = rgb332(frame_model);
		walked[0] = 1'b1;
		for (int k = 1; k < CELLS; k++) begin
			for (int t = 0; t < 4; t++) begin
				nr = row;
				nc = col;
				case (hd)
					stpg_pkg::DIR_EAST:  nc = col + 1;
					stpg_pkg::DIR_SOUTH: nr = row + 1;
					stpg_pkg::DIR_WEST:  nc = col - 1;
					default:             nr = row - 1;
				endcase
				if (nr >= 0 && nr < GRID && nc >= 0 && nc < GRID && !walked[nr * GRID + nc]) begin
					row = nr;
					col = nc;
					walked[row * GRID + col] = 1'b1;
					canvas_model[row * GRID + col] = rgb332(8'(frame_model + (k >> 1)));
					break;
				end
				hd = hd + 2'd1;
			end
		end
	endtask

	// Advance the model by one accepted request and queue the beat it owes
	task automatic pattern_step(input logic req, input logic [9:0] x, input logic [9:0] y);
		pixel_beat_t beat;
		int unsigned cr;
		int unsigned cc;
		beat.color = '0;
		if (req == stpg_pkg::REQ_FRAME) begin
			frame_model = frame_model + 8'd1;
			repaint_canvas();
		end else begin
			cr = y / CELL_H;
			cc = x / CELL_W;
			if (cr < GRID && cc < GRID)
				beat.color = canvas_model[cr * GRID + cc];
		end
		beat.frame_low = frame_model;
		owed_beats.push_back(beat);
	endtask

	// Mostly short idle stretches, a few long ones
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75)
			return $urandom_range(1, 3);
		else if (p < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Drive one request beat, wait for the handshake, then maybe idle
	task automatic send_req(input logic req, input logic [9:0] x, input logic [9:0] y);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {4'b0000, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pattern_step(req, x, y);
		gap = (idling_on && $urandom_range(0, 1)) ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_req(stpg_pkg::REQ_FRAME, 10'($urandom), 10'($urandom));
	endtask

	// Random read: mostly on the covered screen, some on cell borders, some anywhere
	task automatic send_random_read();
		int p;
		logic [9:0] x;
		logic [9:0] y;
		p = $urandom_range(0, 99);
		if (p < 75) begin
			x = 10'($urandom_range(0, GRID * CELL_W - 1));
			y = 10'($urandom_range(0, GRID * CELL_H - 1));
		end else if (p < 88) begin
			x = 10'($urandom_range(0, GRID - 1) * CELL_W +
				($urandom_range(0, 1) ? CELL_W - 1 : 0));
			y = 10'($urandom_range(0, GRID - 1) * CELL_H +
				($urandom_range(0, 1) ? CELL_H - 1 : 0));
		end else begin
			x = 10'($urandom);
			y = 10'($urandom);
		end
		send_req(stpg_pkg::REQ_PIXEL, x, y);
	endtask

	// Reads before any tick see a black canvas
	task automatic test_dark_canvas();
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd799, 10'd599);
		send_req(stpg_pkg::REQ_PIXEL, 10'd400, 10'd300);
		send_req(stpg_pkg::REQ_PIXEL, 10'd1023, 10'd1023);
	endtask

	// First spiral: corners, cell borders and the uncovered band and edge
	task automatic test_first_spiral();
		send_req(stpg_pkg::REQ_FRAME, 10'h3FF, 10'h3FF);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd24, 10'd17);
		send_req(stpg_pkg::REQ_PIXEL, 10'd25, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd18);
		send_req(stpg_pkg::REQ_PIXEL, 10'd799, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd799, 10'd575);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd575);
		send_req(stpg_pkg::REQ_PIXEL, 10'd412, 10'd297);
		send_req(stpg_pkg::REQ_PIXEL, 10'd799, 10'd576);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd599);
		send_req(stpg_pkg::REQ_PIXEL, 10'd800, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd1023, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd1023);
		send_req(stpg_pkg::REQ_PIXEL, 10'd512, 10'd512);
		send_req(stpg_pkg::REQ_FRAME, 10'd0, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd0);
	endtask

	// Tick until the frame counter wraps past 255, one read per frame
	task automatic test_frame_wrap();
		do begin
			send_tick();
			send_random_read();
		end while (frame_model != 8'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd0);
		send_req(stpg_pkg::REQ_PIXEL, 10'd775, 10'd558);
		send_tick();
		send_req(stpg_pkg::REQ_PIXEL, 10'd0, 10'd0);
	endtask

	// Mostly reads with the odd tick, in stretches with and without idling
	task automatic test_random_traffic();
		for (int chunk = 0; chunk < 4; chunk++) begin
			idling_on = (chunk != 1);
			for (int i = 0; i < 150; i++) begin
				if ($urandom_range(0, 99) < 3)
					send_tick();
				else
					send_random_read();
			end
		end
		idling_on = 1'b1;
	endtask

	// Receiver stalls
	always begin
		@(posedge clk);
		if (arst_n && idling_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	// Compare each output beat with the oldest owed one
	always @(posedge clk) begin
		pixel_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %h", m_tdata));
			end else begin
				want = owed_beats.pop_front();
				if (m_tdata[7:0] !== want.color)
					report_mismatch($sformatf("color %h, want %h", m_tdata[7:0], want.color));
				if (m_tdata[15:8] !== want.frame_low)
					report_mismatch($sformatf("frame_low %h, want %h",
						m_tdata[15:8], want.frame_low));
			end
		end
	end

	// Hang detector: cycles in a row with no beat on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int waited;
		frame_model = '0;
		for (int i = 0; i < CELLS; i++) begin
			canvas_model[i] = '0;
			walked[i] = 1'b0;
		end
		err_count = 0;
		idling_on = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dark_canvas();
		test_first_spiral();
		test_frame_wrap();
		test_random_traffic();
		s_tvalid <= 1'b0;

		// Drain, then let the block settle
		waited = 0;
		while (owed_beats.size() != 0 && waited < HANG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (owed_beats.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", owed_beats.size()));

		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/stpg_pkg.sv
design/spiral_test_pattern_generator_unit.sv
dv/tb_spiral_test_pattern_generator_unit.sv
